>>> sv/lvm_pkg.sv
// Shared types and constants for the look-at view matrix unit.
`timescale 1ns / 1ps
`default_nettype none
package lvm_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef logic signed [31:0] fix_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FWD_ZERO = 2'd1,
    ST_UP_ZERO  = 2'd2
  } status_e;

  typedef struct packed {
    fix_t eye_x;
    fix_t eye_y;
    fix_t eye_z;
    fix_t target_x;
    fix_t target_y;
    fix_t target_z;
    fix_t up_x;
    fix_t up_y;
    fix_t up_z;
  } in_word_t;

  typedef struct packed {
    logic [1:0] row_index;
    fix_t       col_a;
    fix_t       col_b;
    fix_t       col_c;
    fix_t       col_d;
    logic       last_row;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] up;
    logic [2:0][32:0] fwd;
    status_e          status;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [2:0][63:0] vec;
  } norm_req_t;

  typedef struct packed {
    logic             done;
    logic [2:0][31:0] res;
  } norm_rsp_t;

endpackage
`default_nettype wire

>>> sv/lvm_if.sv
// Valid/ready channel interfaces for input and result words.
`timescale 1ns / 1ps
`default_nettype none
interface lvm_in_if;
  import lvm_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lvm_out_if;
  import lvm_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/lvm_front.sv
// Front end: accepts words, forms forward vector and status, queues jobs.
`timescale 1ns / 1ps
`default_nettype none
module lvm_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  lvm_in_if.sink             in_i,
  output lvm_pkg::job_t      job_o,
  output logic               job_valid_o,
  input  wire logic          job_ready_i
);
  import lvm_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  job_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  job_t          job_in;
  logic          push, pop;
  logic [2:0][31:0] eye, tgt, up;

  assign eye = {in_i.data.eye_z, in_i.data.eye_y, in_i.data.eye_x};
  assign tgt = {in_i.data.target_z, in_i.data.target_y, in_i.data.target_x};
  assign up  = {in_i.data.up_z, in_i.data.up_y, in_i.data.up_x};

  always_comb begin
    job_in.eye = eye;
    job_in.up  = up;
    for (int i = 0; i < 3; i++) begin
      job_in.fwd[i] = {tgt[i][31], tgt[i]} - {eye[i][31], eye[i]};
    end
    if (job_in.fwd == '0) begin
      job_in.status = ST_FWD_ZERO;
    end else if (up == '0) begin
      job_in.status = ST_UP_ZERO;
    end else begin
      job_in.status = ST_OK;
    end
  end

  assign in_i.ready  = (cnt_q != CW'(QUEUE_DEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign job_valid_o = (cnt_q != '0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= job_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/lvm_norm.sv
// Vector normalizer: scale, sum of squares, bitwise root, restoring divide.
`timescale 1ns / 1ps
`default_nettype none
module lvm_norm #(
  parameter int unsigned FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lvm_pkg::norm_req_t req_i,
  output lvm_pkg::norm_rsp_t     rsp_o
);
  import lvm_pkg::*;

  localparam int unsigned SW = $clog2(FRAC_BITS + 1);

  typedef enum logic [4:0] {
    N_IDLE  = 5'b00001,
    N_SCALE = 5'b00010,
    N_SQ    = 5'b00100,
    N_ROOT  = 5'b01000,
    N_DIV   = 5'b10000
  } nstate_e;

  nstate_e          state_q;
  logic [63:0]      mag_q [3];
  logic [2:0]       neg_q;
  logic [63:0]      sum_q, root_q, bit_q;
  logic [59:0]      prod_q;
  logic             pv_q;
  logic [1:0]       k_q, comp_q;
  logic [32:0]      rem_q;
  logic [FRAC_BITS:0] quo_q;
  logic [SW-1:0]    step_q;
  logic [2:0][31:0] res_q;
  logic             done_q;

  logic [63:0]      m, t;
  logic [63:0]      vabs [3];
  logic [33:0]      r2;
  logic [FRAC_BITS:0] quo_d;
  logic             qb;
  logic [29:0]      msel;
  logic [31:0]      qext;

  always_comb begin
    m = mag_q[0];
    if (mag_q[1] > m) m = mag_q[1];
    if (mag_q[2] > m) m = mag_q[2];
    for (int i = 0; i < 3; i++) begin
      vabs[i] = req_i.vec[i][63] ? (64'd0 - req_i.vec[i]) : req_i.vec[i];
    end
    t     = root_q + bit_q;
    msel  = mag_q[k_q == 2'd3 ? 2'd0 : k_q][29:0];
    r2    = {rem_q, (step_q == '0) ? mag_q[comp_q][0] : 1'b0};
    qb    = (r2 >= {1'b0, root_q[32:0]});
    quo_d = {quo_q[FRAC_BITS-1:0], qb};
    qext  = 32'(quo_d);
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      N_IDLE: begin
        if (req_i.start) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= vabs[i];
            neg_q[i] <= req_i.vec[i][63];
          end
        end
      end
      N_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          if (m[63:38] != '0) mag_q[i] <= mag_q[i] >> 8;
          else if (m[63:30] != '0) mag_q[i] <= mag_q[i] >> 1;
          else if (m[29:21] == '0) mag_q[i] <= mag_q[i] << 8;
          else if (!m[29]) mag_q[i] <= mag_q[i] << 1;
        end
        sum_q <= '0;
      end
      N_SQ: begin
        prod_q <= msel * msel;
        if (pv_q) sum_q <= sum_q + 64'(prod_q);
        root_q <= '0;
        bit_q  <= 64'd1 << 62;
      end
      N_ROOT: begin
        if (sum_q >= t) begin
          sum_q  <= sum_q - t;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
        rem_q <= 33'(mag_q[0][29:1]);
        quo_q <= '0;
      end
      N_DIV: begin
        rem_q <= qb ? 33'(r2 - {1'b0, root_q[32:0]}) : r2[32:0];
        quo_q <= quo_d;
        if (step_q == SW'(FRAC_BITS)) begin
          res_q[comp_q] <= neg_q[comp_q] ? (32'd0 - qext) : qext;
          rem_q <= 33'(mag_q[comp_q == 2'd2 ? 2'd2 : comp_q + 2'd1][29:1]);
          quo_q <= '0;
        end
      end
      default: ;
    endcase
    if (state_q == N_IDLE && req_i.start && vabs[0] == '0 && vabs[1] == '0
        && vabs[2] == '0) begin
      res_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      pv_q    <= 1'b0;
      k_q     <= '0;
      comp_q  <= '0;
      step_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        N_IDLE: begin
          if (req_i.start) begin
            if (vabs[0] == '0 && vabs[1] == '0 && vabs[2] == '0) begin
              done_q <= 1'b1;
            end else begin
              state_q <= N_SCALE;
            end
          end
        end
        N_SCALE: begin
          if (m[63:30] == '0 && m[29]) begin
            state_q <= N_SQ;
            k_q     <= '0;
            pv_q    <= 1'b0;
          end
        end
        N_SQ: begin
          pv_q <= (k_q != 2'd3);
          if (k_q == 2'd3) begin
            state_q <= N_ROOT;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        N_ROOT: begin
          if (bit_q == 64'd1) begin
            state_q <= N_DIV;
            comp_q  <= '0;
            step_q  <= '0;
          end
        end
        N_DIV: begin
          if (step_q == SW'(FRAC_BITS)) begin
            step_q <= '0;
            if (comp_q == 2'd2) begin
              state_q <= N_IDLE;
              done_q  <= 1'b1;
            end else begin
              comp_q <= comp_q + 1'b1;
            end
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/lvm_back.sv
// Back end: sequences normalizations, cross and dot products, emits rows.
`timescale 1ns / 1ps
`default_nettype none
module lvm_back #(
  parameter int unsigned FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lvm_pkg::job_t      job_i,
  input  wire logic               job_valid_i,
  output logic                    job_ready_o,
  output lvm_pkg::norm_req_t      norm_req_o,
  input  wire lvm_pkg::norm_rsp_t norm_rsp_i,
  lvm_out_if.source               out_o
);
  import lvm_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_NSTART = 5'b00010,
    B_NWAIT  = 5'b00100,
    B_MUL    = 5'b01000,
    B_EMIT   = 5'b10000
  } bstate_e;

  typedef enum logic [2:0] {
    PH_FWD    = 3'd0,
    PH_CROSS1 = 3'd1,
    PH_RIGHT  = 3'd2,
    PH_CROSS2 = 3'd3,
    PH_UP     = 3'd4,
    PH_DOT    = 3'd5
  } phase_e;

  bstate_e          state_q;
  phase_e           ph_q;
  job_t             job_q;
  logic [2:0][63:0] acc_q;
  logic [2:0][31:0] ax_q, ay_q, az_q;
  logic [3:0]       k_q;
  logic signed [63:0] prod_q;
  logic [1:0]       pdst_q;
  logic             pneg_q, pv_q;
  logic [1:0]       row_q;
  logic             ovalid_q;
  out_word_t        oword_q;

  logic [1:0]       ia, ib, dst;
  logic             neg;
  logic [3:0]       nprod;
  logic signed [33:0] opa, opb;
  logic signed [67:0] prod;
  logic             load;
  out_word_t        row_w;
  logic [2:0][31:0] axis;

  function automatic logic [31:0] fin(input logic [63:0] p);
    logic [63:0] mag, q;
    mag = p[63] ? (64'd0 - p) : p;
    mag = mag >> FRAC_BITS;
    q   = p[63] ? (64'd0 - mag) : mag;
    if (!q[63] && q[62:31] != '0) return 32'h7fff_ffff;
    if (q[63] && q[62:31] != '1) return 32'h8000_0000;
    return q[31:0];
  endfunction

  always_comb begin
    ia = 2'd0; ib = 2'd0; dst = 2'd0; neg = 1'b0;
    if (ph_q == PH_DOT) begin
      case (k_q)
        4'd0: begin dst = 2'd0; ia = 2'd0; end
        4'd1: begin dst = 2'd0; ia = 2'd1; end
        4'd2: begin dst = 2'd0; ia = 2'd2; end
        4'd3: begin dst = 2'd1; ia = 2'd0; end
        4'd4: begin dst = 2'd1; ia = 2'd1; end
        4'd5: begin dst = 2'd1; ia = 2'd2; end
        4'd6: begin dst = 2'd2; ia = 2'd0; end
        4'd7: begin dst = 2'd2; ia = 2'd1; end
        default: begin dst = 2'd2; ia = 2'd2; end
      endcase
      ib = ia;
    end else begin
      case (k_q)
        4'd0: begin ia = 2'd1; ib = 2'd2; dst = 2'd0; end
        4'd1: begin ia = 2'd2; ib = 2'd1; dst = 2'd0; neg = 1'b1; end
        4'd2: begin ia = 2'd2; ib = 2'd0; dst = 2'd1; end
        4'd3: begin ia = 2'd0; ib = 2'd2; dst = 2'd1; neg = 1'b1; end
        4'd4: begin ia = 2'd0; ib = 2'd1; dst = 2'd2; end
        default: begin ia = 2'd1; ib = 2'd0; dst = 2'd2; neg = 1'b1; end
      endcase
    end
    axis = (dst == 2'd0) ? ax_q : ((dst == 2'd1) ? ay_q : az_q);
    case (ph_q)
      PH_CROSS1: begin
        opa   = 34'(signed'(job_q.up[ia]));
        opb   = 34'(signed'(az_q[ib]));
        nprod = 4'd6;
      end
      PH_CROSS2: begin
        opa   = 34'(signed'(az_q[ia]));
        opb   = 34'(signed'(ax_q[ib]));
        nprod = 4'd6;
      end
      default: begin
        opa   = 34'(signed'(axis[ia]));
        opb   = 34'sd0 - 34'(signed'(job_q.eye[ib]));
        nprod = 4'd9;
      end
    endcase
    prod = opa * opb;
  end

  assign norm_req_o.start = (state_q == B_NSTART);
  assign norm_req_o.vec   = (ph_q == PH_FWD)
      ? {{{31{job_q.fwd[2][32]}}, job_q.fwd[2]},
         {{31{job_q.fwd[1][32]}}, job_q.fwd[1]},
         {{31{job_q.fwd[0][32]}}, job_q.fwd[0]}}
      : acc_q;

  assign job_ready_o = (state_q == B_IDLE);
  assign load        = !ovalid_q || out_o.ready;
  assign out_o.valid = ovalid_q;
  assign out_o.data  = oword_q;

  always_comb begin
    row_w.row_index = row_q;
    row_w.last_row  = (row_q == 2'd3);
    row_w.status    = job_q.status;
    row_w.col_d     = '0;
    if (job_q.status != ST_OK) begin
      row_w.col_a = '0;
      row_w.col_b = '0;
      row_w.col_c = '0;
    end else if (row_q == 2'd3) begin
      row_w.col_a = fin(acc_q[0]);
      row_w.col_b = fin(acc_q[1]);
      row_w.col_c = fin(acc_q[2]);
      row_w.col_d = 32'(64'd1 << FRAC_BITS);
    end else begin
      row_w.col_a = ax_q[row_q];
      row_w.col_b = ay_q[row_q];
      row_w.col_c = az_q[row_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && job_valid_i) begin
      job_q <= job_i;
    end
    if (state_q == B_NWAIT && norm_rsp_i.done) begin
      acc_q <= '0;
      case (ph_q)
        PH_FWD:   az_q <= norm_rsp_i.res;
        PH_RIGHT: ax_q <= norm_rsp_i.res;
        default:  ay_q <= norm_rsp_i.res;
      endcase
    end
    if (state_q == B_MUL) begin
      prod_q <= 64'(prod);
      pdst_q <= dst;
      pneg_q <= neg;
      if (pv_q) begin
        acc_q[pdst_q] <= pneg_q ? acc_q[pdst_q] - prod_q : acc_q[pdst_q] + prod_q;
      end
    end
    if (state_q == B_EMIT && load) begin
      oword_q <= row_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      ph_q     <= PH_FWD;
      k_q      <= '0;
      pv_q     <= 1'b0;
      row_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (out_o.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            row_q   <= '0;
            ph_q    <= PH_FWD;
            state_q <= (job_i.status != ST_OK) ? B_EMIT : B_NSTART;
          end
        end
        B_NSTART: state_q <= B_NWAIT;
        B_NWAIT: begin
          if (norm_rsp_i.done) begin
            state_q <= B_MUL;
            k_q     <= '0;
            pv_q    <= 1'b0;
            case (ph_q)
              PH_FWD:   ph_q <= PH_CROSS1;
              PH_RIGHT: ph_q <= PH_CROSS2;
              default:  ph_q <= PH_DOT;
            endcase
          end
        end
        B_MUL: begin
          pv_q <= (k_q != nprod);
          if (k_q == nprod) begin
            case (ph_q)
              PH_CROSS1: begin ph_q <= PH_RIGHT; state_q <= B_NSTART; end
              PH_CROSS2: begin ph_q <= PH_UP; state_q <= B_NSTART; end
              default:   state_q <= B_EMIT;
            endcase
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        B_EMIT: begin
          if (load) begin
            ovalid_q <= 1'b1;
            row_q    <= row_q + 1'b1;
            if (row_q == 2'd3) state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/look_at_view_matrix_unit.sv
// Top level of the look-at view matrix unit.
// Use: in_i takes one word with eye, target and up (signed Q16.16); out_o
// returns four words per input, rows 0 to 3 of the view matrix, in order,
// last_row marking row 3 and status flagging a zero forward or up vector.
// Both channels are valid/ready; a word moves when both are high.
// The front end classifies each word and queues it (two entries), so input
// is taken while the back end works and while a row waits in the output
// register.
// Each valid item runs three normalizations, each a start step, scale steps,
// the sum of squares, one root bit per cycle for a 32-bit root, one quotient
// bit per cycle for each component, and done. After the first and second run
// the two cross products, after the third the dot products, all on the one
// shared 34x34 multiplier of the back end; then the four rows are emitted.
// An item with a zero forward or up vector goes straight to its four zero rows.
// The back end takes a new job only when idle, after its last row is loaded.
// Reset clears the queue, sequencers and output valid; nothing else.
// A stalled receiver holds the current row in the output register and
// backs up the sequencer, then the queue, then in_i.ready.
`timescale 1ns / 1ps
`default_nettype none
module look_at_view_matrix_unit #(
  parameter int unsigned FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lvm_in_if.sink    in_i,
  lvm_out_if.source out_o
);
  import lvm_pkg::*;

  job_t      job;
  logic      job_valid, job_ready;
  norm_req_t norm_req;
  norm_rsp_t norm_rsp;

  lvm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready)
  );

  lvm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (norm_req),
    .rsp_o  (norm_rsp)
  );

  lvm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .norm_req_o  (norm_req),
    .norm_rsp_i  (norm_rsp),
    .out_o       (out_o)
  );

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.last_row == (out_o.data.row_index == 2'd3)))
    else $error("last_row mismatch");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.status != ST_OK) |->
      (out_o.data.col_a == '0 && out_o.data.col_b == '0 &&
       out_o.data.col_c == '0 && out_o.data.col_d == '0))
    else $error("error row not zero");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.data.last_row) |=>
      (!out_o.valid || out_o.data.row_index == $past(out_o.data.row_index) + 2'd1))
    else $error("row order broken");

  a_row3_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.last_row && out_o.data.status == ST_OK) |->
      (out_o.data.col_d == 32'(64'd1 << FRAC_BITS)))
    else $error("row 3 col_d wrong");

endmodule
`default_nettype wire
